### design/dlisru_pkg.sv
package dlisru_pkg;

	localparam int ACC_W = 40;
	localparam int VAL_W = 16;

	typedef enum logic [1:0] {
		MODE_WEIGHT = 2'd0,
		MODE_BIAS   = 2'd1,
		MODE_ELEM   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_SQRT,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// saturating add of two 40-bit values, summed in 41 bits, into 40 bits
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		begin
			s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
			if (s[ACC_W] != s[ACC_W-1])
				sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
			else
				sat_add = s[ACC_W-1:0];
		end
	endfunction

endpackage

### design/dlisru_cell.sv
// One row of the layer: holds its weights, bias and accumulator. During
// readout the cells form a shift chain toward cell 0.
module dlisru_cell #(
	parameter int IN_DIM = 16,
	parameter int COL_W  = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_weight,
	input  logic                                  wr_bias,
	input  logic                                  elem_en,
	input  logic [COL_W-1:0]                      col,
	input  logic signed [dlisru_pkg::VAL_W-1:0]   value,
	input  logic                                  load,
	input  logic                                  shift,
	input  logic signed [dlisru_pkg::ACC_W-1:0]   z_in,
	output logic signed [dlisru_pkg::ACC_W-1:0]   z_out
);
	logic signed [dlisru_pkg::VAL_W-1:0] weight_q [IN_DIM];
	logic signed [dlisru_pkg::VAL_W-1:0] bias_q;
	logic signed [dlisru_pkg::ACC_W-1:0] acc_q;
	logic signed [dlisru_pkg::ACC_W-1:0] z_q;
	logic signed [2*dlisru_pkg::VAL_W-1:0] prod;
	logic signed [dlisru_pkg::ACC_W-1:0] prod_ext;
	logic signed [dlisru_pkg::ACC_W-1:0] acc_sum;
	logic signed [dlisru_pkg::ACC_W-1:0] bias_ext;

	assign prod     = weight_q[col] * value;
	assign prod_ext = {{(dlisru_pkg::ACC_W-2*dlisru_pkg::VAL_W){prod[2*dlisru_pkg::VAL_W-1]}},
		prod};
	// the last element of a vector still adds its product before z is formed
	assign acc_sum  = elem_en ? dlisru_pkg::sat_add(acc_q, prod_ext) : acc_q;
	assign bias_ext = {{(dlisru_pkg::ACC_W-dlisru_pkg::VAL_W-12){bias_q[dlisru_pkg::VAL_W-1]}},
		bias_q, 12'd0};
	assign z_out    = z_q;

	always_ff @(posedge clk) begin
		if (wr_weight) weight_q[col] <= value;
		if (wr_bias) bias_q <= value;
		if (load) z_q <= dlisru_pkg::sat_add(acc_sum, bias_ext);
		else if (shift) z_q <= z_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (load) begin
			acc_q <= '0;
		end else if (elem_en) begin
			acc_q <= acc_sum;
		end
	end
endmodule

### design/dlisru_act.sv
// ISRU on one z: bit-serial square root (25 steps), then restoring
// division (16 steps).
module dlisru_act (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [dlisru_pkg::ACC_W-1:0]  z,
	output logic                                 done,
	output logic signed [dlisru_pkg::VAL_W-1:0]  y
);
	logic        busy_q, phase_q, neg_q;
	logic [4:0]  cnt_q;
	logic [24:0] a_q;
	logic [49:0] rem_q;
	logic [49:0] root_q;
	logic [49:0] num_q;
	logic [15:0] quo_q;
	logic [40:0] drem_q;
	logic        done_q;
	logic [39:0] mag;
	logic [24:0] a_n;
	logic [49:0] rad_n;
	logic [49:0] trial, rem_sh;
	logic [40:0] dsh;

	always_comb begin
		mag = z[dlisru_pkg::ACC_W-1] ? 40'(-z) : 40'(z);
		if (mag > 40'h1_0000_0000) mag = 40'h1_0000_0000;
		a_n = mag[32:8];
		rad_n = a_n * a_n;
		rad_n = rad_n + 50'h1_0000_0000;
		rem_sh = {rem_q[47:0], num_q[49:48]};
		trial  = {root_q[47:0], 2'b01};
		dsh    = {drem_q[39:0], num_q[49]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && phase_q && cnt_q == 5'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// num_q doubles as the radicand shift (sqrt) and dividend shift (div);
	// the dividend's upper bits a/2 are already below the root, so only its
	// low 16 bits are shifted in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= z[dlisru_pkg::ACC_W-1];
			a_q     <= a_n;
			num_q   <= rad_n;
			rem_q   <= '0;
			root_q  <= '0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q && !phase_q) begin
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[48:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[48:0], 1'b0};
			end
			num_q <= {num_q[47:0], 2'b00};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd24) begin
				phase_q <= 1'b1;
				cnt_q   <= '0;
				num_q   <= {a_q[0], 49'd0};
				drem_q  <= {17'd0, a_q[24:1]};
				quo_q   <= '0;
			end
		end else if (busy_q) begin
			if (dsh >= {16'd0, root_q[24:0]}) begin
				drem_q <= dsh - {16'd0, root_q[24:0]};
				quo_q  <= {quo_q[14:0], 1'b1};
			end else begin
				drem_q <= dsh;
				quo_q  <= {quo_q[14:0], 1'b0};
			end
			num_q <= {num_q[48:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign done = done_q;
	assign y = neg_q ? -$signed({1'b0, quo_q[14:0]}) : $signed({1'b0, quo_q[14:0]});
endmodule

### design/dense_layer_isru_forward_unit.sv
// Writes and non-last elements are taken at 1 item per cycle while the unit accepts input.
// On a last element the row of cells loads z, then each row goes through
// the activation unit: 25 square-root steps plus 16 divide steps, for
// each of the OUT_DIM rows in turn.
// Input is held off during readout.
// Reset clears accumulators and control; weight and bias stores are not cleared.
module dense_layer_isru_forward_unit #(
	parameter int OUT_DIM = 16,
	parameter int IN_DIM  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // mode[1:0], row[5:2], col[9:6], value[25:10], zero pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // neuron[3:0], activation[19:4], zero pad
	output logic        m_tlast
);
	localparam int RW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

	dlisru_pkg::state_t state_q, state_n;
	logic [1:0]  mode;
	logic [3:0]  row, col;
	logic signed [15:0] value;
	logic        acc_in, start, done, load, shift;
	logic [RW:0] rows_q;
	logic signed [dlisru_pkg::ACC_W-1:0] chain [OUT_DIM+1];
	logic signed [15:0] y;
	logic        ov_q, ol_q;
	logic [3:0]  on_q;
	logic [15:0] oa_q;

	assign mode  = s_tdata[1:0];
	assign row   = s_tdata[5:2];
	assign col   = s_tdata[9:6];
	assign value = s_tdata[25:10];
	assign s_tready = (state_q == dlisru_pkg::ST_ACCEPT);
	assign acc_in   = s_tvalid && s_tready;
	assign load     = acc_in && mode == dlisru_pkg::MODE_ELEM && s_tlast;
	assign chain[OUT_DIM] = '0;

	for (genvar r = 0; r < OUT_DIM; r++) begin : g_cell
		dlisru_cell #(.IN_DIM(IN_DIM), .COL_W(4)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr_weight(acc_in && mode == dlisru_pkg::MODE_WEIGHT && 32'(row) == r
				&& 32'(col) < IN_DIM),
			.wr_bias(acc_in && mode == dlisru_pkg::MODE_BIAS && 32'(row) == r),
			.elem_en(acc_in && mode == dlisru_pkg::MODE_ELEM && 32'(col) < IN_DIM),
			.col(col), .value(value), .load(load), .shift(shift),
			.z_in(chain[r+1]), .z_out(chain[r])
		);
	end

	dlisru_act u_act (.clk(clk), .arst_n(arst_n), .start(start), .z(chain[0]),
		.done(done), .y(y));

	always_comb begin
		state_n = state_q;
		case (state_q)
			dlisru_pkg::ST_ACCEPT: if (load) state_n = dlisru_pkg::ST_SQRT;
			dlisru_pkg::ST_SQRT:   state_n = dlisru_pkg::ST_DIV;
			dlisru_pkg::ST_DIV:    if (done) state_n = dlisru_pkg::ST_EMIT;
			dlisru_pkg::ST_EMIT: begin
				if (!ov_q)
					state_n = (32'(rows_q) == OUT_DIM) ? dlisru_pkg::ST_ACCEPT
						: dlisru_pkg::ST_SQRT;
			end
			default: state_n = dlisru_pkg::ST_ACCEPT;
		endcase
	end

	always_comb begin
		start = (state_q == dlisru_pkg::ST_SQRT);
		shift = start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlisru_pkg::ST_ACCEPT;
			rows_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) rows_q <= '0;
			if (ov_q && m_tready) ov_q <= 1'b0;
			if (done) begin
				ov_q   <= 1'b1;
				rows_q <= rows_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			on_q <= 4'(rows_q);
			oa_q <= y;
			ol_q <= (32'(rows_q) == OUT_DIM - 1);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'd0, oa_q, on_q};
	assign m_tlast  = ol_q;
endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ROWS = 16;
	localparam int N_COLS = 16;
	localparam longint MAX_CYCLES = 3000000;

	typedef struct packed {
		logic [3:0]  neuron;
		logic [15:0] activation;
		logic        eov;
	} act_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	dense_layer_isru_forward_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// shadow state of the layer
	logic signed [15:0] weights [N_ROWS][N_COLS];
	logic signed [15:0] biases [N_ROWS];
	logic signed [39:0] accs [N_ROWS];
	act_t               act_queue [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_recv;
	int  hold_cycles;
	int  mismatches;
	bit  failed;
	longint cycle_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > MAX_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
		if (v > 42'sd549755813887) return 40'sh7FFFFFFFFF;
		if (v < -42'sd549755813888) return 40'sh8000000000;
		return v[39:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] isru_q15(input logic signed [39:0] z);
		logic [63:0] mag, a, d, m;
		mag = z[39] ? 64'(-$signed({{24{z[39]}}, z})) : 64'(z);
		if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
		a = mag >> 8;
		d = int_sqrt(a * a + (64'd1 << 32));
		m = (a << 15) / d;
		if (m > 64'd32767) m = 64'd32767;
		return z[39] ? 16'(-m) : 16'(m);
	endfunction

	task automatic predict_layer(input dlisru_pkg::mode_t mode, input int r, input int c,
			input logic signed [15:0] v, input bit lst);
		act_t e;
		case (mode)
			dlisru_pkg::MODE_WEIGHT: weights[r][c] = v;
			dlisru_pkg::MODE_BIAS: biases[r] = v;
			dlisru_pkg::MODE_ELEM: begin
				for (int i = 0; i < N_ROWS; i++)
					accs[i] = sat40(42'(accs[i]) + 42'(weights[i][c] * v));
				if (lst) begin
					for (int i = 0; i < N_ROWS; i++) begin
						e.neuron = 4'(i);
						e.activation = isru_q15(sat40(42'(accs[i]) + 42'(biases[i]) * 4096));
						e.eov = (i == N_ROWS - 1);
						act_queue.push_back(e);
						accs[i] = 0;
					end
				end
			end
			default: ;
		endcase
	endtask

	// tvalid stays up from one transfer to the next unless the sender idles
	task automatic send_item(input dlisru_pkg::mode_t mode, input int r, input int c,
			input logic signed [15:0] v, input bit lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, v, 4'(c), 4'(r), mode};
		s_tlast <= lst;
		predict_layer(mode, r, c, v, lst);
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		act_t got, exp_a;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[3:0], m_tdata[19:4], m_tlast};
			if (act_queue.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer %h", m_tdata);
			end else begin
				exp_a = act_queue.pop_front();
				if (got !== exp_a) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp n=%0d a=%h l=%b got n=%0d a=%h l=%b",
							exp_a.neuron, exp_a.activation, exp_a.eov,
							got.neuron, got.activation, got.eov);
				end
			end
		end
		if (hold_recv) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			if (hold_cycles == 1) hold_recv <= 1'b0;
		end
	end

	function automatic logic [15:0] rand_value();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(8191)) - 4096);
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(511)) - 256);
		endcase
	endfunction

	task automatic load_all(input bit extreme);
		for (int r = 0; r < N_ROWS; r++) begin
			for (int c = 0; c < N_COLS; c++)
				send_item(dlisru_pkg::MODE_WEIGHT, r, c, extreme ? 16'h7FFF : rand_value(),
					$urandom_range(1));
			send_item(dlisru_pkg::MODE_BIAS, r, $urandom_range(15),
				extreme ? 16'h8000 : rand_value(), 0);
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (act_queue.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic test_directed();
		for (int c = 0; c < N_COLS; c++)
			send_item(dlisru_pkg::MODE_WEIGHT, 0, c, 16'h7FFF, 0);
		send_item(dlisru_pkg::MODE_BIAS, 0, 0, 16'h8000, 0);
		// drive row 0 far past the clamp, bias pulls negative
		for (int c = 0; c < N_COLS; c++)
			send_item(dlisru_pkg::MODE_ELEM, 0, c, 16'h7FFF, c == N_COLS - 1);
		send_item(dlisru_pkg::MODE_ELEM, 0, 0, 16'h8000, 1);
		send_item(dlisru_pkg::MODE_ELEM, 0, 3, 16'h0000, 1);
		send_item(dlisru_pkg::MODE_NONE, 15, 15, 16'hFFFF, 1);
		send_item(dlisru_pkg::MODE_ELEM, 15, 15, 16'h0001, 1);
		wait_drain();
	endtask

	task automatic test_random(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			int len;
			len = $urandom_range(N_COLS, 1);
			if ($urandom_range(9) == 0) begin
				send_item(dlisru_pkg::MODE_WEIGHT, $urandom_range(15), $urandom_range(15),
					rand_value(), $urandom_range(1));
				send_item(dlisru_pkg::MODE_BIAS, $urandom_range(15), $urandom_range(15),
					rand_value(), $urandom_range(1));
				send_item(dlisru_pkg::MODE_NONE, $urandom_range(15), $urandom_range(15),
					rand_value(), $urandom_range(1));
				sent += 3;
			end
			for (int k = 0; k < len; k++) begin
				send_item(dlisru_pkg::MODE_ELEM, $urandom_range(15), $urandom_range(15),
					rand_value(), k == len - 1);
				sent++;
			end
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_recv = 1'b1;
		hold_cycles = 2000;
		for (int k = 0; k < 2 * N_COLS; k++)
			send_item(dlisru_pkg::MODE_ELEM, 0, k % N_COLS, rand_value(),
				(k % N_COLS) == N_COLS - 1);
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		hold_recv = 1'b0;
		hold_cycles = 0;
		mismatches = 0;
		failed = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < N_ROWS; i++) accs[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_all(0);
		test_directed();
		send_idle_pct = 32; recv_idle_pct = 77;
		test_random(25);
		send_idle_pct = 77; recv_idle_pct = 32;
		test_random(25);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(25);
		test_backpressure();
		repeat (200) @(posedge clk);
		if (failed || act_queue.size() != 0) $display("Test completed with failures");
		else $display("Test completed successfully");
		$finish;
	end

endmodule
